// ===== rtl/pgw_pkg.sv =====
package pgw_pkg;

	// build-time sizing
	localparam int MAX_SAMPLES = 64;
	localparam int SAMPLE_BITS = 12;

	// fixed field widths
	localparam int SAMPLE_W = 12;
	localparam int REG_W    = 16;
	localparam int CHARGE_W = 22;
	localparam int INDEX_W  = 6;
	localparam int CFG_IDX_W = 2;

	// internal arithmetic widths
	localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
	localparam int DIFF_W = 18;
	localparam int PROD_W = DIFF_W + REG_W + 1;
	localparam int CAL_W  = 24;
	localparam int SUM_W  = 26;
	localparam int POS_W  = SUM_W - 1;

	localparam int CHARGE_MAX = 4194303;
	localparam int INDEX_MAX  = 63;
	localparam int FRAC_SHIFT = 12;

	// divide by three through a reciprocal: ceil(2^27 / 3), exact for 26-bit inputs
	localparam int RECIP_SHIFT = 27;
	localparam int RECIP_W     = 26;
	localparam logic [RECIP_W-1:0] RECIP_THIRD = RECIP_W'(((1 << RECIP_SHIFT) + 2) / 3);
	localparam int QUOT_PROD_W = POS_W + RECIP_W;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

	localparam logic [REG_W-1:0] GAIN_RESET = REG_W'(4096);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PEDESTAL    = 2'd0,
		REG_GAIN        = 2'd1,
		REG_COMMON_MODE = 2'd2
	} cfg_reg_t;

	// one calibrated slice handed from the front end to the peak tracker
	typedef struct packed {
		logic signed [CAL_W-1:0] cal;
		logic                    used;
		logic                    last;
		logic [CNT_W-1:0]        slot;
	} slice_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

// ===== rtl/pgw_front.sv =====
module pgw_front import pgw_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [SAMPLE_W-1:0]  sample,
	input  logic                 last,
	input  logic [REG_W-1:0]     pedestal,
	input  logic [REG_W-1:0]     gain,
	input  logic [REG_W-1:0]     common_mode,
	input  fifo_stat_t           fifo_stat,
	output logic                 push,
	output slice_t               push_slice,
	output logic [CNT_W-1:0]     slice_count
);

	localparam logic [SAMPLE_W-1:0] RAW_MASK = SAMPLE_W'((1 << SAMPLE_BITS) - 1);

	logic                     accept;
	logic                     used;
	logic [SAMPLE_W-1:0]      raw;
	logic signed [DIFF_W-1:0] diff;
	logic                     s1_ready;
	logic                     s2_ready;

	logic [CNT_W-1:0]         cnt_q;

	logic                     v_s1;
	logic signed [DIFF_W-1:0] diff_s1;
	logic                     used_s1;
	logic                     last_s1;
	logic [CNT_W-1:0]         slot_s1;

	logic                     v_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic                     used_s2;
	logic                     last_s2;
	logic [CNT_W-1:0]         slot_s2;

	assign s2_ready = !v_s2 || !fifo_stat.full;
	assign s1_ready = !v_s1 || s2_ready;
	assign in_ready = s1_ready;
	assign accept   = in_valid && in_ready;

	// slices past the capacity are dropped but still close the pulse on last
	assign used = cnt_q < CNT_W'(MAX_SAMPLES);
	assign raw  = sample & RAW_MASK;
	assign diff = $signed({2'b00, pedestal})
	            - $signed({2'b00, raw, 4'b0000})
	            - DIFF_W'($signed(common_mode));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
		end else begin
			if (accept) begin
				if (last) begin
					cnt_q <= '0;
				end else if (used) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (s1_ready) begin
				v_s1 <= accept;
			end
			if (s2_ready) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			diff_s1 <= diff;
			used_s1 <= used;
			last_s1 <= last;
			slot_s1 <= cnt_q;
		end
		if (s2_ready && v_s1) begin
			prod_s2 <= diff_s1 * $signed({1'b0, gain});
			used_s2 <= used_s1;
			last_s2 <= last_s1;
			slot_s2 <= slot_s1;
		end
	end

	// arithmetic shift gives the floor of the product over 4096
	assign push            = v_s2 && !fifo_stat.full;
	assign push_slice.cal  = CAL_W'(prod_s2 >>> FRAC_SHIFT);
	assign push_slice.used = used_s2;
	assign push_slice.last = last_s2;
	assign push_slice.slot = slot_s2;
	assign slice_count     = cnt_q;

endmodule

// ===== rtl/pgw_fifo.sv =====
module pgw_fifo import pgw_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  slice_t     push_slice,
	input  logic       pop,
	output slice_t     head,
	output fifo_stat_t stat
);

	slice_t                entry_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_PTR_W:0]   fill_q;

	assign stat.full  = fill_q == (FIFO_PTR_W + 1)'(FIFO_DEPTH);
	assign stat.empty = fill_q == '0;
	assign head       = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_slice;
		end
	end

endmodule

// ===== rtl/pgw_back.sv =====
module pgw_back import pgw_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  slice_t              head,
	input  fifo_stat_t          fifo_stat,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [CHARGE_W-1:0] charge,
	output logic [INDEX_W-1:0]  peak_index
);

	logic signed [CAL_W-1:0] prev_one_q;
	logic signed [CAL_W-1:0] prev_two_q;
	logic signed [SUM_W-1:0] best_sum_q;
	logic [INDEX_W-1:0]      best_index_q;

	logic signed [SUM_W-1:0] win_sum;
	logic [CNT_W-1:0]        center;
	logic [INDEX_W-1:0]      center_idx;
	logic                    take;
	logic signed [SUM_W-1:0] new_sum;
	logic [INDEX_W-1:0]      new_index;

	logic                    s1_ready;
	logic                    s2_ready;
	logic                    v_s1;
	logic [POS_W-1:0]        sum_s1;
	logic [INDEX_W-1:0]      idx_s1;
	logic                    v_s2;
	logic [QUOT_PROD_W-1:0]  prod_s2;
	logic [INDEX_W-1:0]      idx_s2;
	logic [QUOT_PROD_W-RECIP_SHIFT-1:0] quot;

	assign win_sum = SUM_W'(prev_two_q) + SUM_W'(prev_one_q) + SUM_W'(head.cal);
	assign center  = head.slot - 1'b1;
	assign center_idx = (center > CNT_W'(INDEX_MAX)) ? INDEX_W'(INDEX_MAX) : INDEX_W'(center);
	// strictly larger only, so the earliest window keeps a tie
	assign take = head.used && (head.slot >= CNT_W'(2)) && (win_sum > best_sum_q);

	always_comb begin
		new_sum   = best_sum_q;
		new_index = best_index_q;
		if (take) begin
			new_sum   = win_sum;
			new_index = center_idx;
		end
	end

	assign s2_ready = !v_s2 || out_ready;
	assign s1_ready = !v_s1 || s2_ready;
	assign pop      = !fifo_stat.empty && (!head.last || s1_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_one_q   <= '0;
			prev_two_q   <= '0;
			best_sum_q   <= '0;
			best_index_q <= '0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
		end else begin
			if (pop) begin
				if (head.last) begin
					prev_one_q   <= '0;
					prev_two_q   <= '0;
					best_sum_q   <= '0;
					best_index_q <= '0;
				end else begin
					if (head.used) begin
						prev_two_q <= prev_one_q;
						prev_one_q <= head.cal;
					end
					best_sum_q   <= new_sum;
					best_index_q <= new_index;
				end
			end
			if (s1_ready) begin
				v_s1 <= pop && head.last;
			end
			if (s2_ready) begin
				v_s2 <= v_s1;
			end
		end
	end

	// best sum never drops below zero, so its low bits are the magnitude
	always_ff @(posedge clk) begin
		if (pop && head.last && s1_ready) begin
			sum_s1 <= new_sum[POS_W-1:0];
			idx_s1 <= new_index;
		end
		if (s2_ready && v_s1) begin
			prod_s2 <= QUOT_PROD_W'(sum_s1) * QUOT_PROD_W'(RECIP_THIRD);
			idx_s2  <= idx_s1;
		end
	end

	assign quot       = prod_s2[QUOT_PROD_W-1:RECIP_SHIFT];
	assign out_valid  = v_s2;
	assign charge     = (quot > (QUOT_PROD_W - RECIP_SHIFT)'(CHARGE_MAX))
	                  ? CHARGE_W'(CHARGE_MAX) : quot[CHARGE_W-1:0];
	assign peak_index = idx_s2;

endmodule

// ===== rtl/pedestal_gain_window_peak_finder_top.sv =====
// a result is valid after its tlast word passes the front, queue and back registers
// throughput: one sample word per cycle while the queue has room; results add no gap
// the rate is set by the window update, which folds one slice per cycle (a closing
// slice waits for result room) behind a subtract and a multiply stage of calibration
// reset: pedestal 0, gain 1.0, common mode 0, pulse state and queue cleared at once
// no clearing pass; the block takes words as soon as reset is released
module pedestal_gain_window_peak_finder_top import pgw_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [15:0]          s_axis_tdata,  // [11:0] sample
	input  logic                 s_axis_tlast,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [31:0]          m_axis_tdata,  // [21:0] charge, [27:22] peak_index
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_data
);

	logic [REG_W-1:0]    pedestal_q;
	logic [REG_W-1:0]    gain_q;
	logic [REG_W-1:0]    common_mode_q;

	logic                push;
	logic                pop;
	slice_t              push_slice;
	slice_t              head;
	fifo_stat_t          fifo_stat;
	logic [CNT_W-1:0]    slice_count;
	logic [CHARGE_W-1:0] charge;
	logic [INDEX_W-1:0]  peak_index;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pedestal_q    <= '0;
			gain_q        <= GAIN_RESET;
			common_mode_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PEDESTAL:    pedestal_q    <= cfg_data;
				REG_GAIN:        gain_q        <= cfg_data;
				REG_COMMON_MODE: common_mode_q <= cfg_data;
				default: ;
			endcase
		end
	end

	pgw_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.sample      (s_axis_tdata[SAMPLE_W-1:0]),
		.last        (s_axis_tlast),
		.pedestal    (pedestal_q),
		.gain        (gain_q),
		.common_mode (common_mode_q),
		.fifo_stat   (fifo_stat),
		.push        (push),
		.push_slice  (push_slice),
		.slice_count (slice_count)
	);

	pgw_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_slice (push_slice),
		.pop        (pop),
		.head       (head),
		.stat       (fifo_stat)
	);

	pgw_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.fifo_stat  (fifo_stat),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.charge     (charge),
		.peak_index (peak_index)
	);

	assign m_axis_tdata = {4'b0000, peak_index, charge};

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && fifo_stat.full))
		else $error("slice queue written while full");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && fifo_stat.empty))
		else $error("slice queue read while empty");

	a_count_clears: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tlast |=> slice_count == '0)
		else $error("slice count not cleared after last word");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		slice_count <= CNT_W'(MAX_SAMPLES))
		else $error("slice count beyond capacity");

endmodule

// ===== tb/peak_result_checker.sv =====
`timescale 1ns / 1ps

module peak_result_checker
	import pgw_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	input  logic                 s_axis_tready,
	input  logic [15:0]          s_axis_tdata,  // [11:0] sample
	input  logic                 s_axis_tlast,
	input  logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	input  logic [31:0]          m_axis_tdata,  // [21:0] charge, [27:22] peak_index
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_data,
	output int                   fail_count,
	output int                   results_pending
);

	typedef struct packed {
		logic [INDEX_W-1:0]  peak_index;
		logic [CHARGE_W-1:0] charge;
	} pulse_peak_t;

	pulse_peak_t pending_peaks[$];

	// calibration registers as the block should hold them
	logic        [REG_W-1:0] pedestal_q    = '0;
	logic        [REG_W-1:0] gain_q        = GAIN_RESET;
	logic signed [REG_W-1:0] common_mode_q = '0;

	// running pulse state
	int          cal_one;
	int          cal_two;
	int unsigned slices_seen;
	int          best_window;
	logic [INDEX_W-1:0] best_center;
	int          mismatches;

	function automatic void clear_pulse_state();
		cal_one     = 0;
		cal_two     = 0;
		slices_seen = 0;
		best_window = 0;
		best_center = '0;
	endfunction

	// gain * (pedestal - 16 * raw - common mode), floor of the product over 2^12
	function automatic int calibrate_slice(input logic [SAMPLE_W-1:0] raw);
		longint diff;
		longint prod;
		diff = longint'(pedestal_q) - longint'(raw) * 16 - longint'(common_mode_q);
		prod = diff * longint'(gain_q);
		return int'(prod >>> FRAC_SHIFT);
	endfunction

	// advances the pulse by one word; returns 1 when the word closes the pulse
	function automatic bit take_slice(input logic [SAMPLE_W-1:0] raw, input bit last,
			output pulse_peak_t peak);
		int cal;
		int window;
		int avg;
		peak = '0;
		if (slices_seen < MAX_SAMPLES) begin
			cal = calibrate_slice(raw);
			if (slices_seen >= 2) begin
				window = cal_two + cal_one + cal;
				if (window > best_window) begin
					best_window = window;
					best_center = INDEX_W'((slices_seen - 1 > INDEX_MAX) ? INDEX_MAX
						: slices_seen - 1);
				end
			end
			cal_two = cal_one;
			cal_one = cal;
			slices_seen++;
		end
		if (!last)
			return 1'b0;
		if (best_window > 0) begin
			avg = best_window / 3;
			peak.charge     = CHARGE_W'((avg > CHARGE_MAX) ? CHARGE_MAX : avg);
			peak.peak_index = best_center;
		end
		clear_pulse_state();
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pulse_peak_t got;
		pulse_peak_t want;
		pulse_peak_t fresh;
		if (!arst_n) begin
			pending_peaks.delete();
			pedestal_q    = '0;
			gain_q        = GAIN_RESET;
			common_mode_q = '0;
			clear_pulse_state();
			mismatches    = 0;
			fail_count      <= 0;
			results_pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
				REG_PEDESTAL:    pedestal_q    = cfg_data;
				REG_GAIN:        gain_q        = cfg_data;
				REG_COMMON_MODE: common_mode_q = cfg_data;
				default: ;
				endcase
			end

			if (m_axis_tvalid && m_axis_tready) begin
				got = pulse_peak_t'(m_axis_tdata[CHARGE_W+INDEX_W-1:0]);
				if (pending_peaks.size() == 0) begin
					$error("unexpected result word: charge %0d peak_index %0d",
						got.charge, got.peak_index);
					mismatches++;
				end else begin
					want = pending_peaks.pop_front();
					if (got.charge !== want.charge) begin
						$error("charge: expected %0d, got %0d", want.charge, got.charge);
						mismatches++;
					end
					if (got.peak_index !== want.peak_index) begin
						$error("peak_index: expected %0d, got %0d",
							want.peak_index, got.peak_index);
						mismatches++;
					end
				end
			end

			if (s_axis_tvalid && s_axis_tready) begin
				if (take_slice(s_axis_tdata[SAMPLE_W-1:0], s_axis_tlast, fresh))
					pending_peaks.insert(pending_peaks.size(), fresh);
			end

			fail_count      <= mismatches;
			results_pending <= pending_peaks.size();
		end
	end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import pgw_pkg::*;

	localparam int IDLE_LIMIT    = 4000;
	localparam int PHASES        = 8;
	localparam int PHASE_SAMPLES = 110;

	typedef enum logic [1:0] {
		SHAPE_NOISE,
		SHAPE_FLAT,
		SHAPE_RAMP,
		SHAPE_DIP
	} pulse_shape_t;

	typedef enum logic [1:0] {
		READY_ALWAYS,
		READY_RANDOM,
		READY_PATTERN,
		READY_BURSTY
	} ready_mode_t;

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [15:0]          s_axis_tdata  = '0;  // [11:0] sample
	logic                 s_axis_tlast  = 1'b0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [31:0]          m_axis_tdata;        // [21:0] charge, [27:22] peak_index
	logic                 cfg_valid     = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index     = REG_PEDESTAL;
	logic [REG_W-1:0]     cfg_data      = '0;

	int          fail_count;
	int          results_pending;
	int          idle_cycles = 0;
	int          burst_left  = 20;
	int          samples_sent = 0;
	ready_mode_t ready_mode  = READY_ALWAYS;
	int          ready_tick  = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	pedestal_gain_window_peak_finder_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	peak_result_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_axis_tvalid   (s_axis_tvalid),
		.s_axis_tready   (s_axis_tready),
		.s_axis_tdata    (s_axis_tdata),
		.s_axis_tlast    (s_axis_tlast),
		.m_axis_tvalid   (m_axis_tvalid),
		.m_axis_tready   (m_axis_tready),
		.m_axis_tdata    (m_axis_tdata),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.fail_count      (fail_count),
		.results_pending (results_pending)
	);

	// result side backpressure; the pattern is picked anew at random as the tick counter runs
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			ready_tick <= ready_tick + 1;
			if (ready_tick % 512 == 0)
				ready_mode <= ready_mode_t'($urandom_range(0, 3));
			case (ready_mode)
			READY_ALWAYS:  m_axis_tready <= 1'b1;
			READY_RANDOM:  m_axis_tready <= ($urandom_range(0, 3) != 0);
			READY_PATTERN: m_axis_tready <= (ready_tick % 7 < 3);
			default:       m_axis_tready <= (ready_tick % 32 < 20);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
					|| (cfg_valid && cfg_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAILED: results differ");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	task automatic send_sample(input int value, input bit last);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {4'h0, SAMPLE_W'(value)};
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		samples_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			gap = $urandom_range(1, 12);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 24);
		end
	endtask

	// stop sending until every expected word is back, then let the pipe settle
	task automatic wait_for_results(input int settle);
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (results_pending != 0);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_config(input int pedestal, input int gain, input int common_mode);
		cfg_valid <= 1'b1;
		for (int r = 0; r < 3; r++) begin
			case (r)
			0: begin
				cfg_index <= REG_PEDESTAL;
				cfg_data  <= REG_W'(pedestal);
			end
			1: begin
				cfg_index <= REG_GAIN;
				cfg_data  <= REG_W'(gain);
			end
			default: begin
				cfg_index <= REG_COMMON_MODE;
				cfg_data  <= REG_W'(common_mode);
			end
			endcase
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
	endtask

	// raw samples sit near base but for noise; a dip pulls the raw count below it
	task automatic send_pulse(input int len, input pulse_shape_t shape, input int base);
		int v;
		int centre;
		int depth;
		int dist_c;
		centre = $urandom_range(0, len - 1);
		depth  = $urandom_range(0, 600);
		for (int i = 0; i < len; i++) begin
			case (shape)
			SHAPE_NOISE: v = $urandom_range(0, 4095);
			SHAPE_FLAT:  v = base;
			SHAPE_RAMP:  v = base + 40 - i * 6;
			default: begin
				dist_c = (i > centre) ? i - centre : centre - i;
				v = base + $urandom_range(0, 32) - 16;
				if (dist_c <= 2)
					v = v - depth / (1 + dist_c);
			end
			endcase
			if (v < 0)
				v = 0;
			if (v > 4095)
				v = 4095;
			send_sample(v, i == len - 1);
		end
	endtask

	initial begin
		int ped;
		int gain;
		int cm;
		int base;
		int len;
		int target;
		pulse_shape_t shape;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// reset calibration: every slice is zero or negative
		send_sample(0, 1'b0);
		send_sample(4095, 1'b0);
		send_sample(0, 1'b1);
		send_sample(5, 1'b1);

		wait_for_results(8);
		write_config(65535, 65535, -32768);
		// largest calibrated slices
		send_sample(0, 1'b0);
		send_sample(0, 1'b0);
		send_sample(0, 1'b1);
		// equal windows, the first one stays
		repeat (3) send_sample(7, 1'b0);
		send_sample(7, 1'b1);
		send_sample(4095, 1'b0);
		send_sample(2048, 1'b0);
		send_sample(0, 1'b0);
		send_sample(4095, 1'b1);
		send_sample(9, 1'b0);
		send_sample(9, 1'b1);

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
			0: begin
				ped  = 0;
				gain = 0;
				cm   = 32767;
			end
			1: begin
				ped  = 65535;
				gain = 4096;
				cm   = 32767;
			end
			2: begin
				ped  = 65535;
				gain = 65535;
				cm   = -32768;
			end
			default: begin
				ped  = $urandom_range(0, 65535);
				gain = ($urandom_range(0, 2) == 0) ? $urandom_range(3500, 4700)
					: $urandom_range(0, 65535);
				cm   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) - 32768
					: $urandom_range(0, 4095) - 2048;
			end
			endcase
			base = (ped - cm) / 16;
			if (base < 0)
				base = 0;
			if (base > 4095)
				base = 4095;

			wait_for_results(8);
			write_config(ped, gain, cm);

			target = samples_sent + PHASE_SAMPLES;
			while (samples_sent < target) begin
				shape = pulse_shape_t'($urandom_range(0, 3));
				case ($urandom_range(0, 19))
				0, 1: begin
					len   = $urandom_range(60, 80);
					shape = ($urandom_range(0, 1) == 0) ? SHAPE_RAMP : shape;
				end
				2:       len = $urandom_range(1, 2);
				default: len = $urandom_range(3, 12);
				endcase
				send_pulse(len, shape, base);
				if ($urandom_range(0, 39) == 0)
					wait_for_results(0);
			end
		end

		wait_for_results(20);
		if (fail_count == 0 && results_pending == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
